[design/lfhd_pkg.sv]
// Package for the LLC frame header decoder.
// Holds the input and result item types, status and command codes and framing constants.
// No dependencies.
package lfhd_pkg;

  // Framing constants
  localparam int MAX_FRAME_LENGTH = 2047;
  localparam int FCS_OCTETS       = 3;
  localparam int UI_HEADER_OCTETS = 3;
  localparam int N202             = 4;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_PD    = 3'd2;
  localparam logic [2:0] ST_SAPI  = 3'd3;
  localparam logic [2:0] ST_UCODE = 3'd4;
  localparam logic [2:0] ST_SACK  = 3'd5;

  // Frame command codes
  localparam logic [3:0] CMD_NULL = 4'd0;
  localparam logic [3:0] CMD_RR   = 4'd1;
  localparam logic [3:0] CMD_ACK  = 4'd2;
  localparam logic [3:0] CMD_RNR  = 4'd3;
  localparam logic [3:0] CMD_SACK = 4'd4;
  localparam logic [3:0] CMD_DM   = 4'd5;
  localparam logic [3:0] CMD_DISC = 4'd6;
  localparam logic [3:0] CMD_UA   = 4'd7;
  localparam logic [3:0] CMD_SABM = 4'd8;
  localparam logic [3:0] CMD_FRMR = 4'd9;
  localparam logic [3:0] CMD_XID  = 4'd10;
  localparam logic [3:0] CMD_UI   = 4'd11;

  // One frame header as presented on the input channel
  typedef struct packed {
    logic [7:0]  address_octet;
    logic [7:0]  control_octet_0;
    logic [7:0]  control_octet_1;
    logic [7:0]  control_octet_2;
    logic [7:0]  control_octet_3;
    logic [10:0] frame_length;
    logic [23:0] trailer_fcs;
  } lfhd_in_t;

  // One decoded header on the result channel
  typedef struct packed {
    logic [2:0]  status;
    logic        is_command;
    logic [3:0]  sapi;
    logic        ack_request;
    logic        encrypted;
    logic [3:0]  frame_command;
    logic [8:0]  send_sequence;
    logic [8:0]  receive_sequence;
    logic [5:0]  payload_offset;
    logic [10:0] payload_length;
    logic [10:0] fcs_coverage;
    logic [23:0] received_fcs;
  } lfhd_out_t;

endpackage

[design/lfhd_if.sv]
// Valid/ready channel interfaces for the LLC frame header decoder.
// Depends on lfhd_pkg for the payload types.
interface lfhd_in_if;
  import lfhd_pkg::*;
  logic     valid;
  logic     ready;
  lfhd_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lfhd_out_if;
  import lfhd_pkg::*;
  logic      valid;
  logic      ready;
  lfhd_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/lfhd_decode.sv]
// Combinational header decode: one registered frame header in, one result item out.
// Depends on lfhd_pkg.
module lfhd_decode (
  input  lfhd_pkg::lfhd_in_t  item,
  output lfhd_pkg::lfhd_out_t res
);
  import lfhd_pkg::*;

  // Supervisory function bits to command
  function automatic logic [3:0] sup_cmd(input logic [1:0] bits);
    logic [3:0] c;
    case (bits)
      2'd0:    c = CMD_RR;
      2'd1:    c = CMD_ACK;
      2'd2:    c = CMD_RNR;
      default: c = CMD_SACK;
    endcase
    return c;
  endfunction

  logic [7:0]  addr, c0, c1, c2, c3;
  logic [10:0] len;
  logic [10:0] body;
  logic        len_bad;
  logic        sapi_rsvd;
  logic        u_bad;
  logic [3:0]  cmd;
  logic        ack, enc;
  logic [8:0]  ns, nr;
  logic [5:0]  off;
  logic [10:0] plen, cov;
  logic [10:0] off_ext;

  assign addr = item.address_octet;
  assign c0   = item.control_octet_0;
  assign c1   = item.control_octet_1;
  assign c2   = item.control_octet_2;
  assign c3   = item.control_octet_3;
  assign len  = item.frame_length;

  assign len_bad   = (len <= 11'(FCS_OCTETS)) || (int'(len) > MAX_FRAME_LENGTH);
  assign body      = len - 11'(FCS_OCTETS);
  assign sapi_rsvd = addr[3:0] inside {4'd0, 4'd4, 4'd6, 4'd10, 4'd12, 4'd13, 4'd15};

  // Format decode of the control field
  always_comb begin
    cmd   = CMD_NULL;
    ack   = 1'b0;
    enc   = 1'b0;
    ns    = '0;
    nr    = '0;
    off   = '0;
    u_bad = 1'b0;
    cov   = body;
    if (!c0[7]) begin
      // I format
      ack = c0[6];
      ns  = {c0[4:0], c1[7:4]};
      nr  = {c1[2:0], c2[7:2]};
      cmd = sup_cmd(c2[1:0]);
      if (cmd == CMD_SACK) begin
        off = 6'd5 + {1'b0, c3[4:0]};
      end else begin
        off = 6'd4;
      end
    end else if (c0[7:6] == 2'b10) begin
      // S format
      ack = c0[5];
      nr  = {c0[2:0], c1[7:2]};
      cmd = sup_cmd(c1[1:0]);
    end else if (c0[7:5] == 3'b110) begin
      // UI format; coverage clipped unless full FCS requested
      cmd = CMD_UI;
      off = 6'(UI_HEADER_OCTETS);
      ns  = {c0[2:0], c1[7:2]};
      enc = c1[1];
      if (!c1[0] && (body > 11'(UI_HEADER_OCTETS + N202))) begin
        cov = 11'(UI_HEADER_OCTETS + N202);
      end
    end else begin
      // U format
      case (c0[3:0])
        4'h0:    cmd = CMD_NULL;
        4'h1:    cmd = CMD_DM;
        4'h4:    cmd = CMD_DISC;
        4'h6:    cmd = CMD_UA;
        4'h7:    cmd = CMD_SABM;
        4'h8:    cmd = CMD_FRMR;
        4'hb: begin
          cmd = CMD_XID;
          off = 6'd2;
        end
        default: u_bad = 1'b1;
      endcase
    end
  end

  // Information field length, saturated at zero
  assign off_ext = {5'b0, off};
  assign plen    = (off != '0 && body > off_ext) ? body - off_ext : '0;

  // Error priority and field masking
  always_comb begin
    res = '0;
    if (len_bad) begin
      res.status = ST_SHORT;
    end else begin
      res.fcs_coverage = body;
      res.received_fcs = item.trailer_fcs;
      if (addr[7]) begin
        res.status = ST_PD;
      end else begin
        res.is_command = ~addr[6];
        res.sapi       = addr[3:0];
        if (sapi_rsvd) begin
          res.status = ST_SAPI;
        end else if (u_bad) begin
          res.status = ST_UCODE;
        end else begin
          res.status           = (cmd == CMD_SACK) ? ST_SACK : ST_OK;
          res.ack_request      = ack;
          res.encrypted        = enc;
          res.frame_command    = cmd;
          res.send_sequence    = ns;
          res.receive_sequence = nr;
          res.payload_offset   = off;
          res.payload_length   = plen;
          res.fcs_coverage     = cov;
        end
      end
    end
  end

endmodule

[design/llc_frame_header_decoder_unit.sv]
// Top level of the LLC frame header decoder: input register, decode, result register.
// Depends on lfhd_pkg, lfhd_if and lfhd_decode.
//
//  channel | dir | payload     | transfer when
//  in_ch   | in  | lfhd_in_t   | in_ch.valid && in_ch.ready
//  out_ch  | out | lfhd_out_t  | out_ch.valid && out_ch.ready
//
// One header can be taken per cycle while out_ch is not stalled; its result passes
// through the input register and the result register before it is valid on out_ch.
// Each of the two register stages refills as it empties.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// A stall on out_ch back-pressures in_ch only once both stages hold an item.
module llc_frame_header_decoder_unit (
  input logic clk,
  input logic rst_n,
  lfhd_in_if.sink    in_ch,
  lfhd_out_if.source out_ch
);
  import lfhd_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  lfhd_in_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  lfhd_out_t out_item_r;
  lfhd_out_t dec_res;
  logic      out_free;
  logic      s1_free;

  // Stage enables: a stage loads when it is empty or its content moves on
  assign out_free      = !out_valid_r || out_ch.ready;
  assign s1_free       = !s1_valid_r || out_free;
  assign in_ch.ready   = s1_free;
  assign s1_valid_nxt  = s1_free ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  lfhd_decode u_decode (
    .item (s1_item_r),
    .res  (dec_res)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_item_r <= in_ch.payload;
    end
    if (out_free && s1_valid_r) begin
      out_item_r <= dec_res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

endmodule

[design/lfhd_checker.sv]
// Port-level checks for the LLC frame header decoder, bound to the top level.
// Depends on lfhd_pkg.
module lfhd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input lfhd_pkg::lfhd_out_t out_item
);
  import lfhd_pkg::*;

  // No result straight after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Short frames report nothing else
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_SHORT |->
      out_item.received_fcs == '0 && out_item.fcs_coverage == '0 &&
      out_item.sapi == '0 && out_item.frame_command == CMD_NULL)
    else $error("short frame carries fields");

  // Invalid PD leaves address and control fields clear
  a_pd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_PD |->
      !out_item.is_command && out_item.sapi == '0 &&
      out_item.payload_length == '0 && out_item.frame_command == CMD_NULL)
    else $error("invalid PD frame carries header fields");

endmodule

bind llc_frame_header_decoder_unit lfhd_checker u_lfhd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

[tb/tb_llc_frame_header_decoder_unit.sv]
// Self-checking testbench for the LLC frame header decoder unit.
// Feeds directed and random frame headers, predicts each decoded result and
// compares it field by field. Depends on lfhd_pkg, lfhd_if and the decoder top level.
module tb_llc_frame_header_decoder_unit;
  import lfhd_pkg::*;

  localparam int NUM_RANDOM_FRAMES = 1500;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES    = 100;
  localparam int HOLDOFF_AT_RESULT = 250;
  localparam int QUIET_FIRST       = 700;
  localparam int QUIET_LAST        = 1000;
  localparam int TAIL_CYCLES       = 10;

  // SAPIs 0, 4, 6, 10, 12, 13 and 15 are reserved
  localparam logic [15:0] RESERVED_SAPI_MASK = 16'b1011_0100_0101_0001;

  // Supervisory bits and U format modifier codes
  localparam logic [1:0] SUP_RR   = 2'd0;
  localparam logic [1:0] SUP_ACK  = 2'd1;
  localparam logic [1:0] SUP_RNR  = 2'd2;
  localparam logic [1:0] SUP_SACK = 2'd3;
  localparam logic [3:0] U_NULL   = 4'h0;
  localparam logic [3:0] U_DM     = 4'h1;
  localparam logic [3:0] U_DISC   = 4'h4;
  localparam logic [3:0] U_UA     = 4'h6;
  localparam logic [3:0] U_SABM   = 4'h7;
  localparam logic [3:0] U_FRMR   = 4'h8;
  localparam logic [3:0] U_XID    = 4'hB;

  logic clk;
  logic rst_n = 1'b0;

  lfhd_in_if  in_bus ();
  lfhd_out_if out_bus ();

  llc_frame_header_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  lfhd_in_t  frame_queue[$];
  lfhd_out_t expected_headers[$];
  int        errors = 0;
  int        frames_sent = 0;
  int        headers_checked = 0;
  int        holdoff_left = 0;
  bit        holdoff_done = 1'b0;
  int        stall_free_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Supervisory function bits to command
  function automatic logic [3:0] supervisory_command(input logic [1:0] bits);
    case (bits)
      SUP_RR:  return CMD_RR;
      SUP_ACK: return CMD_ACK;
      SUP_RNR: return CMD_RNR;
      default: return CMD_SACK;
    endcase
  endfunction

  // Information field length, saturated at zero
  function automatic logic [10:0] info_length(input logic [10:0] body, input logic [5:0] offset);
    return (body > offset) ? 11'(body - offset) : 11'd0;
  endfunction

  // Predicted decode of one frame header
  function automatic lfhd_out_t decode_header(input lfhd_in_t h);
    lfhd_out_t   r;
    logic [10:0] body;
    r = '0;
    if (h.frame_length <= FCS_OCTETS || h.frame_length > MAX_FRAME_LENGTH) begin
      r.status = ST_SHORT;
      return r;
    end
    body = 11'(h.frame_length - FCS_OCTETS);
    r.fcs_coverage = body;
    r.received_fcs = h.trailer_fcs;
    if (h.address_octet[7]) begin
      r.status = ST_PD;
      return r;
    end
    r.is_command = ~h.address_octet[6];
    r.sapi       = h.address_octet[3:0];
    if (RESERVED_SAPI_MASK[r.sapi]) begin
      r.status = ST_SAPI;
      return r;
    end
    if (!h.control_octet_0[7]) begin
      // I format; SACK skips the bitmap and its length octet
      r.ack_request      = h.control_octet_0[6];
      r.send_sequence    = {h.control_octet_0[4:0], h.control_octet_1[7:4]};
      r.receive_sequence = {h.control_octet_1[2:0], h.control_octet_2[7:2]};
      r.frame_command    = supervisory_command(h.control_octet_2[1:0]);
      r.payload_offset   = 6'd4;
      if (r.frame_command == CMD_SACK)
        r.payload_offset = 6'(5 + h.control_octet_3[4:0]);
      r.payload_length = info_length(body, r.payload_offset);
    end else if (!h.control_octet_0[6]) begin
      // S format
      r.ack_request      = h.control_octet_0[5];
      r.receive_sequence = {h.control_octet_0[2:0], h.control_octet_1[7:2]};
      r.frame_command    = supervisory_command(h.control_octet_1[1:0]);
    end else if (!h.control_octet_0[5]) begin
      // UI format; coverage limited unless full FCS requested
      r.frame_command  = CMD_UI;
      r.payload_offset = 6'(UI_HEADER_OCTETS);
      r.payload_length = info_length(body, r.payload_offset);
      r.send_sequence  = {h.control_octet_0[2:0], h.control_octet_1[7:2]};
      r.encrypted      = h.control_octet_1[1];
      if (!h.control_octet_1[0] && body > UI_HEADER_OCTETS + N202)
        r.fcs_coverage = 11'(UI_HEADER_OCTETS + N202);
    end else begin
      // U format
      case (h.control_octet_0[3:0])
        U_NULL: r.frame_command = CMD_NULL;
        U_DM:   r.frame_command = CMD_DM;
        U_DISC: r.frame_command = CMD_DISC;
        U_UA:   r.frame_command = CMD_UA;
        U_SABM: r.frame_command = CMD_SABM;
        U_FRMR: r.frame_command = CMD_FRMR;
        U_XID: begin
          r.frame_command  = CMD_XID;
          r.payload_offset = 6'd2;
          r.payload_length = info_length(body, r.payload_offset);
        end
        default: begin
          r.status = ST_UCODE;
          return r;
        end
      endcase
    end
    if (r.frame_command == CMD_SACK)
      r.status = ST_SACK;
    return r;
  endfunction

  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic [7:0] c3, input logic [10:0] len,
                             input logic [23:0] fcs);
    lfhd_in_t f;
    f.address_octet   = addr;
    f.control_octet_0 = c0;
    f.control_octet_1 = c1;
    f.control_octet_2 = c2;
    f.control_octet_3 = c3;
    f.frame_length    = len;
    f.trailer_fcs     = fcs;
    frame_queue.push_back(f);
  endtask

  task automatic report_field(input string field, input logic [23:0] exp_v,
                              input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  // Driver: next frame offered once the current one is transferred
  always @(posedge clk) begin
    bit quiet;
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.payload <= '0;
    end else if (!in_bus.valid || in_bus.ready) begin
      quiet = (frames_sent >= QUIET_FIRST && frames_sent < QUIET_LAST);
      if (frame_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
        in_bus.payload <= frame_queue.pop_front();
        in_bus.valid   <= 1'b1;
        frames_sent++;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: records transfers in, checks transfers out, drives ready
  always @(posedge clk) begin
    lfhd_out_t want;
    lfhd_out_t got;
    bit        take;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_headers.push_back(decode_header(in_bus.payload));
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.payload;
        if (expected_headers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %0h", $time, got);
        end else begin
          want = expected_headers.pop_front();
          report_field("status", want.status, got.status);
          report_field("is_command", want.is_command, got.is_command);
          report_field("sapi", want.sapi, got.sapi);
          report_field("ack_request", want.ack_request, got.ack_request);
          report_field("encrypted", want.encrypted, got.encrypted);
          report_field("frame_command", want.frame_command, got.frame_command);
          report_field("send_sequence", want.send_sequence, got.send_sequence);
          report_field("receive_sequence", want.receive_sequence, got.receive_sequence);
          report_field("payload_offset", want.payload_offset, got.payload_offset);
          report_field("payload_length", want.payload_length, got.payload_length);
          report_field("fcs_coverage", want.fcs_coverage, got.fcs_coverage);
          report_field("received_fcs", want.received_fcs, got.received_fcs);
        end
        headers_checked++;
      end
      // one long hold-off to fill the pipeline, otherwise sparse random stalls outside a quiet window
      if (holdoff_left > 0) begin
        holdoff_left--;
        take = 1'b0;
      end else if (!holdoff_done && headers_checked >= HOLDOFF_AT_RESULT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        take = 1'b0;
      end else begin
        take = (headers_checked >= QUIET_FIRST && headers_checked < QUIET_LAST) ||
               ($urandom_range(0, 99) >= 10);
      end
      out_bus.ready <= take;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        stall_free_cycles = 0;
      else
        stall_free_cycles++;
      if (stall_free_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [3:0] usable_sapi [9];
    logic [3:0] known_u_codes [7];
    logic [7:0] addr;
    logic [7:0] c0;
    logic [10:0] len;
    int         pick;
    usable_sapi   = '{4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd9, 4'd11, 4'd14};
    known_u_codes = '{U_NULL, U_DM, U_DISC, U_UA, U_SABM, U_FRMR, U_XID};

    // short frames, invalid PD, reserved SAPIs
    queue_frame(8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 11'd0, 24'hFFFFFF);
    queue_frame(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'd3, 24'h123456);
    queue_frame(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 11'd10, 24'h000001);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'd2047, 24'hFFFFFF);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 11'd4, 24'h000000);
    queue_frame(8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 11'd20, 24'hA5A5A5);
    // I format: all supervisory functions, SACK bitmap, saturated length
    queue_frame(8'h01, 8'h7F, 8'hFF, 8'hFC, 8'h00, 11'd2047, 24'hABCDEF);
    queue_frame(8'h73, 8'h40, 8'h0F, 8'h01, 8'h00, 11'd30, 24'h5A5A5A);
    queue_frame(8'h35, 8'h1F, 8'hF8, 8'h02, 8'hFF, 11'd5, 24'h0F0F0F);
    queue_frame(8'h0E, 8'h00, 8'h00, 8'h03, 8'h1F, 11'd40, 24'h112233);
    queue_frame(8'h0E, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 11'd20, 24'h445566);
    // S format
    queue_frame(8'h42, 8'hBF, 8'hFC, 8'h00, 8'h00, 11'd6, 24'h778899);
    queue_frame(8'h02, 8'h80, 8'h01, 8'hFF, 8'hFF, 11'd4, 24'hFEDCBA);
    queue_frame(8'h07, 8'h9A, 8'h02, 8'h00, 8'h00, 11'd100, 24'h010203);
    queue_frame(8'h0B, 8'hA5, 8'hFF, 8'h00, 8'h1F, 11'd100, 24'h040506);
    // UI format: limited coverage, full coverage, short body
    queue_frame(8'h03, 8'hC7, 8'hFE, 8'h00, 8'h00, 11'd100, 24'h070809);
    queue_frame(8'h03, 8'hDF, 8'h01, 8'hFF, 8'hFF, 11'd100, 24'h0A0B0C);
    queue_frame(8'h43, 8'hC0, 8'h00, 8'h00, 8'h00, 11'd6, 24'h0D0E0F);
    queue_frame(8'h03, 8'hC0, 8'h02, 8'h00, 8'h00, 11'd11, 24'h101112);
    // U format: every known code, XID with no room, unknown codes
    queue_frame(8'h01, 8'hE0, 8'h00, 8'h00, 8'h00, 11'd4, 24'h131415);
    queue_frame(8'h01, 8'hF1, 8'hFF, 8'hFF, 8'hFF, 11'd8, 24'h161718);
    queue_frame(8'h41, 8'hE4, 8'h00, 8'h00, 8'h00, 11'd8, 24'h191A1B);
    queue_frame(8'h41, 8'hF6, 8'h00, 8'h00, 8'h00, 11'd8, 24'h1C1D1E);
    queue_frame(8'h05, 8'hE7, 8'h00, 8'h00, 8'h00, 11'd8, 24'h1F2021);
    queue_frame(8'h05, 8'hE8, 8'h00, 8'h00, 8'h00, 11'd8, 24'h222324);
    queue_frame(8'h09, 8'hEB, 8'h00, 8'h00, 8'h00, 11'd4, 24'h252627);
    queue_frame(8'h09, 8'hEB, 8'h00, 8'h00, 8'h00, 11'd50, 24'h28292A);
    queue_frame(8'h09, 8'hE2, 8'h00, 8'h00, 8'h00, 11'd50, 24'h2B2C2D);
    queue_frame(8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'd50, 24'h2E2F30);

    // random frames: mostly well formed headers, the rest raw noise
    for (int i = 0; i < NUM_RANDOM_FRAMES; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        addr = {1'b0, 3'($urandom), usable_sapi[$urandom_range(0, 8)]};
        case ($urandom_range(0, 3))
          0: c0 = {1'b0, 7'($urandom)};
          1: c0 = {2'b10, 6'($urandom)};
          2: c0 = {3'b110, 5'($urandom)};
          default: begin
            if ($urandom_range(0, 99) < 80)
              c0 = {3'b111, 1'($urandom), known_u_codes[$urandom_range(0, 6)]};
            else
              c0 = {3'b111, 5'($urandom)};
          end
        endcase
      end else begin
        addr = 8'($urandom);
        c0   = 8'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80)
        len = 11'($urandom_range(4, 48));
      else if (pick < 88)
        len = 11'($urandom_range(0, 3));
      else
        len = 11'($urandom);
      queue_frame(addr, c0, 8'($urandom), 8'($urandom), 8'($urandom), len, 24'($urandom));
    end

    // reset, then wait for every frame to be transferred and decoded
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (frame_queue.size() > 0 || in_bus.valid)
      @(posedge clk);
    while (expected_headers.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
design/lfhd_pkg.sv
design/lfhd_if.sv
design/lfhd_decode.sv
design/llc_frame_header_decoder_unit.sv
design/lfhd_checker.sv
tb/tb_llc_frame_header_decoder_unit.sv
